[design/ldhs_pkg.sv]
// Shared types and constants for the LED heat diffusion sweep core.
// Used by the channel interfaces and by the top level; depends on nothing.
package ldhs_pkg;

	// Geometry
	localparam int STRIP_COUNT         = 4;
	localparam int LEDS_PER_STRIP_DEF  = 64;

	// Field widths
	localparam int HEAT_W     = 17;
	localparam int INDEX_W    = 8;
	localparam int GAP_W      = 8;
	localparam int STRIP_W    = 2;
	localparam int LED_POS_W  = 6;
	localparam int COLOR_W    = 8;
	localparam int COEF_W     = 16;

	typedef logic [HEAT_W-1:0]  heat_t;
	typedef logic [GAP_W-1:0]   gap_t;
	typedef logic [COLOR_W-1:0] color_t;
	typedef logic [COEF_W-1:0]  coef_t;

	// Item modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_SWEEP = 1'b1;

	// Heat constants, Q1.16
	localparam heat_t HEAT_FULL = 17'd65536;
	localparam heat_t HEAT_MAX  = 17'h1FFFF;
	localparam coef_t COEF_SELF = 16'd52298;  // ~0.798
	localparam coef_t COEF_SIDE = 16'd6554;   // ~0.1

	// Color mapping
	localparam int     BLUE_SHIFT = 5;         // heat * 2048 >> 16
	localparam color_t COLOR_MAX  = 8'd255;
	localparam color_t HUE_CAP    = 8'd170;
	localparam color_t DIM_LIMIT  = 8'd192;

	// Register reset values
	localparam heat_t THRESH_RST     = 17'd1311;
	localparam gap_t  RESEED_GAP_RST = 8'd50;
	localparam gap_t  START_GAP_RST  = 8'd10;

	// Configuration port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_THRESH     = 2'd0,
		REG_RESEED_GAP = 2'd1,
		REG_START_GAP  = 2'd2
	} reg_idx_t;

endpackage

[design/ldhs_cmd_if.sv]
// Command channel: load or sweep items into the heat diffusion core.
// Depends on ldhs_pkg for field widths.
interface ldhs_cmd_if;
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic [ldhs_pkg::INDEX_W-1:0]     cell_index;
	logic [ldhs_pkg::HEAT_W-1:0]      load_value;

	modport source (output valid, output mode, output cell_index, output load_value,
		input ready);
	modport sink (input valid, input mode, input cell_index, input load_value,
		output ready);
endinterface

[design/ldhs_pixel_if.sv]
// Pixel channel: one HSV pixel per sweep item out of the heat diffusion core.
// Depends on ldhs_pkg for field widths.
interface ldhs_pixel_if;
	logic                             valid;
	logic                             ready;
	logic [ldhs_pkg::STRIP_W-1:0]     strip;
	logic [ldhs_pkg::LED_POS_W-1:0]   led_position;
	logic [ldhs_pkg::COLOR_W-1:0]     hue;
	logic [ldhs_pkg::COLOR_W-1:0]     brightness;
	logic                             last_of_frame;

	modport source (output valid, output strip, output led_position, output hue,
		output brightness, output last_of_frame, input ready);
	modport sink (input valid, input strip, input led_position, input hue,
		input brightness, input last_of_frame, output ready);
endinterface

[design/led_heat_diffusion_sweep_core.sv]
// Top level of the LED heat diffusion sweep core: heat memory, diffusion datapath,
// reseed logic, HSV mapping and APB register file. Depends on ldhs_pkg and the
// ldhs_cmd_if / ldhs_pixel_if channel interfaces.
//
// The core holds one Q1.16 heat value per LED over four strips of LEDS_PER_STRIP
// cells in a memory with one write port and two read ports. It takes one command
// per clock while not refused: a load writes one cell (an index out of range writes
// nothing), a sweep processes the next cell in order and produces one pixel (hue,
// brightness). The transfer reads the cell and its right neighbor from memory into
// stage 1; when stage 1 advances, the core computes the new heat, writes it back and
// loads the pixel register. Writes still in flight are forwarded to the reads, so
// loads and sweeps may be mixed freely. The pixel register decouples the output: a
// command is refused only while a sweep result sits in the pipeline behind a stalled
// pixel. Registers (APB, byte address 4*i): 0 reseed threshold, 1 reseed gap,
// 2 start gap; write them only while the core is idle.
module led_heat_diffusion_sweep_core #(
	parameter int LEDS_PER_STRIP = ldhs_pkg::LEDS_PER_STRIP_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ldhs_cmd_if.sink                          cmd,
	ldhs_pixel_if.source                      pixel,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ldhs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [ldhs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [ldhs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	localparam int CELL_COUNT = ldhs_pkg::STRIP_COUNT * LEDS_PER_STRIP;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int LED_W      = (LEDS_PER_STRIP > 1) ? $clog2(LEDS_PER_STRIP) : 1;
	localparam int IDX_EXT_W  = ADDR_W + ldhs_pkg::INDEX_W;
	localparam int LED_EXT_W  = LED_W + ldhs_pkg::LED_POS_W;
	localparam int BLUE_RAW_W = ldhs_pkg::HEAT_W - ldhs_pkg::BLUE_SHIFT;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [LED_W-1:0]  led_t;

	localparam addr_t LAST_CELL = addr_t'(CELL_COUNT - 1);
	localparam led_t  LAST_LED  = led_t'(LEDS_PER_STRIP - 1);

	// Q1.16 scaling: (h * c) >> 16, truncated
	function automatic ldhs_pkg::heat_t scale_q16(input ldhs_pkg::heat_t h,
		input ldhs_pkg::coef_t c);
		logic [ldhs_pkg::HEAT_W+ldhs_pkg::COEF_W-1:0] prod;
		prod = {{ldhs_pkg::COEF_W{1'b0}}, h} * {{ldhs_pkg::HEAT_W{1'b0}}, c};
		return prod[ldhs_pkg::HEAT_W+ldhs_pkg::COEF_W-1:ldhs_pkg::COEF_W];
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	ldhs_pkg::heat_t thresh_q;
	ldhs_pkg::gap_t  reseed_gap_q;
	ldhs_pkg::gap_t  start_gap_q;
	logic            cfg_wr;
	logic [ldhs_pkg::REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[ldhs_pkg::APB_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q     <= ldhs_pkg::THRESH_RST;
			reseed_gap_q <= ldhs_pkg::RESEED_GAP_RST;
			start_gap_q  <= ldhs_pkg::START_GAP_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				ldhs_pkg::REG_THRESH:     thresh_q     <= pwdata[ldhs_pkg::HEAT_W-1:0];
				ldhs_pkg::REG_RESEED_GAP: reseed_gap_q <= pwdata[ldhs_pkg::GAP_W-1:0];
				ldhs_pkg::REG_START_GAP:  start_gap_q  <= pwdata[ldhs_pkg::GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (reg_idx)
			ldhs_pkg::REG_THRESH:
				prdata = ldhs_pkg::APB_DATA_W'(thresh_q);
			ldhs_pkg::REG_RESEED_GAP:
				prdata = ldhs_pkg::APB_DATA_W'(reseed_gap_q);
			ldhs_pkg::REG_START_GAP:
				prdata = ldhs_pkg::APB_DATA_W'(start_gap_q);
			default:
				prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Handshake and pipeline control
	// ------------------------------------------------------------------
	logic  valid_s1;
	logic  mode_s1;
	logic  pix_valid_s2;
	logic  out_free;
	logic  s1_adv;
	logic  sweep_s1;
	logic  cmd_xfer;
	logic  sweep_xfer;

	assign out_free   = !pix_valid_s2 || pixel.ready;
	assign sweep_s1   = valid_s1 && (mode_s1 == ldhs_pkg::MODE_SWEEP);
	assign s1_adv     = valid_s1 && ((mode_s1 == ldhs_pkg::MODE_LOAD) || out_free);
	assign cmd.ready  = !valid_s1 || s1_adv;
	assign cmd_xfer   = cmd.valid && cmd.ready;
	assign sweep_xfer = cmd_xfer && (cmd.mode == ldhs_pkg::MODE_SWEEP);

	// ------------------------------------------------------------------
	// Sweep position counters
	// ------------------------------------------------------------------
	addr_t                          pos_q;
	led_t                           led_q;
	logic [ldhs_pkg::STRIP_W-1:0]   strip_q;
	logic                           last_cell;

	assign last_cell = (pos_q == LAST_CELL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			led_q   <= '0;
			strip_q <= '0;
		end else if (sweep_xfer) begin
			if (last_cell) begin
				pos_q   <= '0;
				led_q   <= '0;
				strip_q <= '0;
			end else begin
				pos_q <= addr_t'(pos_q + 1'b1);
				if (led_q == LAST_LED) begin
					led_q   <= '0;
					strip_q <= strip_q + 1'b1;
				end else begin
					led_q <= led_t'(led_q + 1'b1);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Load address decode
	// ------------------------------------------------------------------
	logic [IDX_EXT_W-1:0] idx_ext;
	logic                 load_ok;

	assign idx_ext = {{ADDR_W{1'b0}}, cmd.cell_index};
	assign load_ok = (idx_ext < IDX_EXT_W'(CELL_COUNT));

	// ------------------------------------------------------------------
	// Stage 1 registers: command fields and sweep context
	// ------------------------------------------------------------------
	addr_t                          load_addr_s1;
	logic                           load_ok_s1;
	ldhs_pkg::heat_t                load_value_s1;
	addr_t                          pos_s1;
	led_t                           led_s1;
	logic [ldhs_pkg::STRIP_W-1:0]   strip_s1;
	logic                           last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			mode_s1       <= cmd.mode;
			load_addr_s1  <= idx_ext[ADDR_W-1:0];
			load_ok_s1    <= load_ok;
			load_value_s1 <= cmd.load_value;
			pos_s1        <= pos_q;
			led_s1        <= led_q;
			strip_s1      <= strip_q;
			last_s1       <= last_cell;
		end
	end

	// ------------------------------------------------------------------
	// Heat memory: one write port, two registered read ports
	// ------------------------------------------------------------------
	ldhs_pkg::heat_t heat_mem [CELL_COUNT];

	logic            wr_en;
	addr_t           wr_addr;
	ldhs_pkg::heat_t wr_data;
	addr_t           rd_self_addr;
	addr_t           rd_right_addr;
	ldhs_pkg::heat_t self_rd_s1;
	ldhs_pkg::heat_t right_rd_s1;
	logic            self_byp_s1;
	logic            right_byp_s1;
	ldhs_pkg::heat_t byp_data_s1;
	ldhs_pkg::heat_t next_heat;

	assign wr_en   = s1_adv && (sweep_s1 || load_ok_s1);
	assign wr_addr = sweep_s1 ? pos_s1 : load_addr_s1;
	assign wr_data = sweep_s1 ? next_heat : load_value_s1;

	// The last cell uses its own heat in place of a right neighbor
	assign rd_self_addr  = pos_q;
	assign rd_right_addr = last_cell ? pos_q : addr_t'(pos_q + 1'b1);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			heat_mem[wr_addr] <= wr_data;
		end
		if (sweep_xfer) begin
			self_rd_s1  <= heat_mem[rd_self_addr];
			right_rd_s1 <= heat_mem[rd_right_addr];
		end
	end

	// Forward the write landing on the same edge as the read
	always_ff @(posedge clk) begin
		if (sweep_xfer) begin
			self_byp_s1  <= wr_en && (wr_addr == rd_self_addr);
			right_byp_s1 <= wr_en && (wr_addr == rd_right_addr);
			byp_data_s1  <= wr_data;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 datapath: reseed decision and diffusion
	// ------------------------------------------------------------------
	ldhs_pkg::heat_t            self_heat;
	ldhs_pkg::heat_t            right_heat;
	ldhs_pkg::heat_t            left_heat;
	ldhs_pkg::heat_t            left_q;
	ldhs_pkg::gap_t             gap_q;
	ldhs_pkg::gap_t             gap_base;
	ldhs_pkg::gap_t             gap_dec;
	ldhs_pkg::gap_t             gap_next;
	logic                       first_s1;
	logic                       reseed;
	logic [ldhs_pkg::HEAT_W:0]  heat_sum;
	ldhs_pkg::heat_t            diffused;

	assign self_heat  = self_byp_s1 ? byp_data_s1 : self_rd_s1;
	assign right_heat = right_byp_s1 ? byp_data_s1 : right_rd_s1;
	assign first_s1   = (pos_s1 == '0);
	assign left_heat  = first_s1 ? self_heat : left_q;

	// Gap count: reload at sweep start, count down, reload after a reseed
	assign gap_base = first_s1 ? start_gap_q : gap_q;
	assign gap_dec  = (gap_base != '0) ? ldhs_pkg::gap_t'(gap_base - 1'b1) : gap_base;
	assign reseed   = (self_heat < thresh_q) && (gap_dec == '0);
	assign gap_next = reseed ? reseed_gap_q : gap_dec;

	assign heat_sum = {1'b0, scale_q16(self_heat, ldhs_pkg::COEF_SELF)}
		+ {1'b0, scale_q16(left_heat, ldhs_pkg::COEF_SIDE)}
		+ {1'b0, scale_q16(right_heat, ldhs_pkg::COEF_SIDE)};
	assign diffused = heat_sum[ldhs_pkg::HEAT_W] ? ldhs_pkg::HEAT_MAX
		: heat_sum[ldhs_pkg::HEAT_W-1:0];
	assign next_heat = reseed ? ldhs_pkg::HEAT_FULL : diffused;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q  <= '0;
			left_q <= '0;
		end else if (s1_adv && sweep_s1) begin
			gap_q  <= gap_next;
			left_q <= self_heat;
		end
	end

	// ------------------------------------------------------------------
	// HSV mapping
	// ------------------------------------------------------------------
	logic [BLUE_RAW_W-1:0] blue_raw;
	ldhs_pkg::color_t      blue;
	ldhs_pkg::color_t      hue_raw;
	ldhs_pkg::color_t      hue;
	ldhs_pkg::color_t      bright;

	assign blue_raw = next_heat[ldhs_pkg::HEAT_W-1:ldhs_pkg::BLUE_SHIFT];
	assign blue     = (blue_raw > BLUE_RAW_W'(ldhs_pkg::COLOR_MAX)) ? ldhs_pkg::COLOR_MAX
		: blue_raw[ldhs_pkg::COLOR_W-1:0];
	assign hue_raw  = ldhs_pkg::COLOR_MAX - blue;
	// Dim cells scale brightness by four; blue stays under 64 there
	assign bright   = (hue_raw > ldhs_pkg::DIM_LIMIT) ? {blue[ldhs_pkg::COLOR_W-3:0], 2'b00}
		: ldhs_pkg::COLOR_MAX;
	assign hue      = (hue_raw > ldhs_pkg::HUE_CAP) ? ldhs_pkg::HUE_CAP : hue_raw;

	// ------------------------------------------------------------------
	// Pixel output register
	// ------------------------------------------------------------------
	logic [LED_EXT_W-1:0]            led_ext;
	logic [ldhs_pkg::STRIP_W-1:0]    strip_s2;
	logic [ldhs_pkg::LED_POS_W-1:0]  led_pos_s2;
	ldhs_pkg::color_t                hue_s2;
	ldhs_pkg::color_t                bright_s2;
	logic                            last_s2;

	assign led_ext = {{ldhs_pkg::LED_POS_W{1'b0}}, led_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_s2 <= 1'b0;
		end else if (out_free) begin
			pix_valid_s2 <= s1_adv && sweep_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && sweep_s1) begin
			strip_s2   <= strip_s1;
			led_pos_s2 <= led_ext[ldhs_pkg::LED_POS_W-1:0];
			hue_s2     <= hue;
			bright_s2  <= bright;
			last_s2    <= last_s1;
		end
	end

	assign pixel.valid         = pix_valid_s2;
	assign pixel.strip         = strip_s2;
	assign pixel.led_position  = led_pos_s2;
	assign pixel.hue           = hue_s2;
	assign pixel.brightness    = bright_s2;
	assign pixel.last_of_frame = last_s2;

endmodule
